### src/llr_primality_test_k2n_minus1_core_macros.svh
// Assertion helpers for the LLR core.
`ifndef LLR_PRIMALITY_TEST_K2N_MINUS1_CORE_MACROS_SVH
`define LLR_PRIMALITY_TEST_K2N_MINUS1_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define LLRK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("llrk assertion failed");

// Next-cycle implication.
`define LLRK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("llrk assertion failed");

`endif

### src/llrk_pkg.sv
`timescale 1ns / 1ps
package llrk_pkg;

  localparam logic [15:0] P_LIMIT   = 16'd65535;
  localparam logic [4:0]  SQUARINGS = 5'd30;
  localparam logic [5:0]  BIT_LAST  = 6'd63;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_KZERO  = 2'd1,
    ST_NOBASE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_JSTART,
    S_JMOD,
    S_JCHK,
    S_MUL,
    S_D,
    S_TOP,
    S_BIT,
    S_UV,
    S_VV,
    S_UP,
    S_UD,
    S_VP,
    S_SQ,
    S_SQR,
    S_DONE
  } state_t;

  function automatic logic [63:0] mod_add(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] n);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, n}) s = s - {1'b0, n};
    return s[63:0];
  endfunction

  function automatic logic [63:0] mod_sub(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] n);
    return (a < b) ? (n - b + a) : (a - b);
  endfunction

  function automatic logic [63:0] mod_half(input logic [63:0] v, input logic [63:0] n);
    return v[0] ? ((v >> 1) + (n >> 1) + 64'd1) : (v >> 1);
  endfunction

endpackage

### src/llrk_in_if.sv
`timescale 1ns / 1ps
interface llrk_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] multiplier_k;
  modport source (output valid, output multiplier_k, input ready);
  modport sink (input valid, input multiplier_k, output ready);
endinterface

### src/llrk_out_if.sv
`timescale 1ns / 1ps
interface llrk_out_if;
  logic        valid;
  logic        ready;
  logic        is_probable_prime;
  logic [15:0] lucas_base;
  logic [1:0]  status;
  modport source (output valid, output is_probable_prime, output lucas_base,
                  output status, input ready);
  modport sink (input valid, input is_probable_prime, input lucas_base,
                input status, output ready);
endinterface

### src/llr_primality_test_k2n_minus1_core.sv
// Operation: k = 0 goes straight to the done state; otherwise each Jacobi reduction runs
// bit-serially, and each modular product runs in the shared bit-serial multiply/reduce unit:
// one for D, 2 or 5 per bit of k below its top bit, and 30 squarings, plus the base search.
// Throughput: one item at a time; the next item is taken once the previous is finished.
// Reset: synchronous, active low; clears the sequencer and the output valid.
`timescale 1ns / 1ps
`include "llr_primality_test_k2n_minus1_core_macros.svh"
module llr_primality_test_k2n_minus1_core
  import llrk_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  llrk_in_if.sink      in_bus,
  llrk_out_if.source   out_bus
);

  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] k_r, k_nxt;
  logic [63:0] n_r, n_nxt, ma_r, ma_nxt, mb_r, mb_nxt, acc_r, acc_nxt;
  logic [63:0] ja_r, ja_nxt, jm_r, jm_nxt;
  logic [63:0] u_r, u_nxt, v_r, v_nxt, d_r, d_nxt, t_r, t_nxt, w_r, w_nxt;
  logic [15:0] p_r, p_nxt;
  logic        sel_r, sel_nxt, jneg_r, jneg_nxt, zpar_r, zpar_nxt;
  logic [4:0]  bidx_r, bidx_nxt, bcnt_r, bcnt_nxt, sq_r, sq_nxt;
  logic        rprime_r, rprime_nxt;
  logic [15:0] rbase_r, rbase_nxt;
  status_t     rstat_r, rstat_nxt;
  logic        out_valid_r, ld_out;
  logic        oprime_r;
  logic [15:0] obase_r;
  status_t     ostat_r;
  logic [64:0] rr;
  logic [63:0] r2;
  logic [4:0]  bm1;
  logic [63:0] p64;

  assign p64 = {48'd0, p_r};
  assign bm1 = bcnt_r - 5'd1;

  assign in_bus.ready              = (state_r == S_IDLE);
  assign out_bus.valid             = out_valid_r;
  assign out_bus.is_probable_prime = oprime_r;
  assign out_bus.lucas_base        = obase_r;
  assign out_bus.status            = ostat_r;

  always_comb begin
    state_nxt = state_r;  ret_nxt = ret_r;  cnt_nxt = cnt_r;
    k_nxt = k_r;  n_nxt = n_r;  ma_nxt = ma_r;  mb_nxt = mb_r;  acc_nxt = acc_r;
    ja_nxt = ja_r;  jm_nxt = jm_r;  u_nxt = u_r;  v_nxt = v_r;  d_nxt = d_r;
    t_nxt = t_r;  w_nxt = w_r;  p_nxt = p_r;  sel_nxt = sel_r;  jneg_nxt = jneg_r;
    zpar_nxt = zpar_r;  bidx_nxt = bidx_r;  bcnt_nxt = bcnt_r;  sq_nxt = sq_r;
    rprime_nxt = rprime_r;  rbase_nxt = rbase_r;  rstat_nxt = rstat_r;
    ld_out = 1'b0;
    rr = {acc_r, mb_r[63]};
    if (rr >= {1'b0, jm_r}) rr = rr - {1'b0, jm_r};
    r2 = mod_add(acc_r, acc_r, n_r);
    unique case (state_r)
      S_IDLE: begin
        if (in_bus.valid) begin
          k_nxt = in_bus.multiplier_k;
          n_nxt = {in_bus.multiplier_k, 32'd0} - 64'd1;
          p_nxt = 16'd3;
          sel_nxt = 1'b0;
          if (in_bus.multiplier_k == 32'd0) begin
            rprime_nxt = 1'b0;  rbase_nxt = 16'd0;  rstat_nxt = ST_KZERO;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_JSTART;
          end
        end
      end
      S_JSTART: begin
        mb_nxt = sel_r ? (p64 + 64'd2) : (p64 - 64'd2);
        jm_nxt = n_r;
        jneg_nxt = 1'b0;
        zpar_nxt = 1'b0;
        acc_nxt = '0;
        cnt_nxt = BIT_LAST;
        state_nxt = S_JMOD;
      end
      S_JMOD: begin
        // restoring remainder, one dividend bit per cycle
        acc_nxt = rr[63:0];
        mb_nxt = mb_r << 1;
        if (cnt_r == 6'd0) begin
          ja_nxt = rr[63:0];
          state_nxt = S_JCHK;
        end else begin
          cnt_nxt = cnt_r - 6'd1;
        end
      end
      S_JCHK: begin
        if (ja_r == 64'd0) begin
          if (!sel_r && jm_r == 64'd1 && !jneg_r) begin
            sel_nxt = 1'b1;
            state_nxt = S_JSTART;
          end else if (sel_r && jm_r == 64'd1 && jneg_r) begin
            ma_nxt = p64;  mb_nxt = p64;  acc_nxt = '0;  cnt_nxt = BIT_LAST;
            ret_nxt = S_D;  state_nxt = S_MUL;
          end else if (p_r == P_LIMIT) begin
            rprime_nxt = 1'b0;  rbase_nxt = 16'd0;  rstat_nxt = ST_NOBASE;
            state_nxt = S_DONE;
          end else begin
            p_nxt = p_r + 16'd1;
            sel_nxt = 1'b0;
            state_nxt = S_JSTART;
          end
        end else if (!ja_r[0]) begin
          ja_nxt = ja_r >> 1;
          zpar_nxt = ~zpar_r;
        end else begin
          jneg_nxt = jneg_r ^ ((zpar_r & (jm_r[1] ^ jm_r[2])) ^ (ja_r[1] & jm_r[1]));
          jm_nxt = ja_r;
          mb_nxt = jm_r;
          zpar_nxt = 1'b0;
          acc_nxt = '0;
          cnt_nxt = BIT_LAST;
          state_nxt = S_JMOD;
        end
      end
      S_MUL: begin
        // double, then add the multiplicand when the multiplier bit is set
        acc_nxt = mb_r[63] ? mod_add(r2, ma_r, n_r) : r2;
        mb_nxt = mb_r << 1;
        if (cnt_r == 6'd0) state_nxt = ret_r;
        else cnt_nxt = cnt_r - 6'd1;
      end
      S_D: begin
        d_nxt = mod_sub(acc_r, 64'd4, n_r);
        bidx_nxt = 5'd31;
        state_nxt = S_TOP;
      end
      S_TOP: begin
        if (k_r[bidx_r] || bidx_r == 5'd0) begin
          bcnt_nxt = bidx_r;
          u_nxt = 64'd1;
          v_nxt = p64;
          state_nxt = S_BIT;
        end else begin
          bidx_nxt = bidx_r - 5'd1;
        end
      end
      S_BIT: begin
        acc_nxt = '0;  cnt_nxt = BIT_LAST;
        if (bcnt_r == 5'd0) begin
          sq_nxt = SQUARINGS;
          state_nxt = S_SQ;
        end else begin
          ma_nxt = u_r;  mb_nxt = v_r;  ret_nxt = S_UV;  state_nxt = S_MUL;
        end
      end
      S_UV: begin
        t_nxt = acc_r;
        ma_nxt = v_r;  mb_nxt = v_r;  acc_nxt = '0;  cnt_nxt = BIT_LAST;
        ret_nxt = S_VV;  state_nxt = S_MUL;
      end
      S_VV: begin
        u_nxt = t_r;
        v_nxt = mod_sub(acc_r, 64'd2, n_r);
        if (k_r[bm1]) begin
          ma_nxt = t_r;  mb_nxt = p64;  acc_nxt = '0;  cnt_nxt = BIT_LAST;
          ret_nxt = S_UP;  state_nxt = S_MUL;
        end else begin
          bcnt_nxt = bm1;
          state_nxt = S_BIT;
        end
      end
      S_UP: begin
        t_nxt = acc_r;
        ma_nxt = u_r;  mb_nxt = d_r;  acc_nxt = '0;  cnt_nxt = BIT_LAST;
        ret_nxt = S_UD;  state_nxt = S_MUL;
      end
      S_UD: begin
        w_nxt = acc_r;
        ma_nxt = v_r;  mb_nxt = p64;  acc_nxt = '0;  cnt_nxt = BIT_LAST;
        ret_nxt = S_VP;  state_nxt = S_MUL;
      end
      S_VP: begin
        u_nxt = mod_half(mod_add(t_r, v_r, n_r), n_r);
        v_nxt = mod_half(mod_add(w_r, acc_r, n_r), n_r);
        bcnt_nxt = bm1;
        state_nxt = S_BIT;
      end
      S_SQ: begin
        if (sq_r == 5'd0) begin
          rprime_nxt = (v_r == 64'd0);
          rbase_nxt = p_r;
          rstat_nxt = ST_OK;
          state_nxt = S_DONE;
        end else begin
          ma_nxt = v_r;  mb_nxt = v_r;  acc_nxt = '0;  cnt_nxt = BIT_LAST;
          ret_nxt = S_SQR;  state_nxt = S_MUL;
        end
      end
      S_SQR: begin
        v_nxt = mod_sub(acc_r, 64'd2, n_r);
        sq_nxt = sq_r - 5'd1;
        state_nxt = S_SQ;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_bus.ready) begin
          ld_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      if (ld_out) out_valid_r <= 1'b1;
      else if (out_bus.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;  k_r <= k_nxt;  n_r <= n_nxt;  ma_r <= ma_nxt;  mb_r <= mb_nxt;
    acc_r <= acc_nxt;  ja_r <= ja_nxt;  jm_r <= jm_nxt;  u_r <= u_nxt;  v_r <= v_nxt;
    d_r <= d_nxt;  t_r <= t_nxt;  w_r <= w_nxt;  p_r <= p_nxt;  sel_r <= sel_nxt;
    jneg_r <= jneg_nxt;  zpar_r <= zpar_nxt;  bidx_r <= bidx_nxt;  bcnt_r <= bcnt_nxt;
    sq_r <= sq_nxt;  rprime_r <= rprime_nxt;  rbase_r <= rbase_nxt;  rstat_r <= rstat_nxt;
    if (ld_out) begin
      oprime_r <= rprime_r;
      obase_r <= rbase_r;
      ostat_r <= rstat_r;
    end
  end

  `LLRK_ASSERT_NEXT(a_kzero_done, in_bus.valid && in_bus.ready && in_bus.multiplier_k == 32'd0, state_r == S_DONE)
  `LLRK_ASSERT_NOW(a_prime_ok, out_valid_r && oprime_r, ostat_r == ST_OK)
  `LLRK_ASSERT_NOW(a_err_base, out_valid_r && ostat_r != ST_OK, obase_r == 16'd0 && !oprime_r)
  `LLRK_ASSERT_NEXT(a_mul_hold, state_r == S_MUL && cnt_r != 6'd0, state_r == S_MUL)

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
module tb;
  import llrk_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 8_000_000;
  localparam int unsigned RANDOM_ITEMS = 100;
  localparam int unsigned LONG_HOLD = 40_000;
  localparam int unsigned DRAIN_CYCLES = 200;

  typedef struct packed {
    logic        prime;
    logic [15:0] base;
    status_t     st;
  } verdict_t;

  typedef struct {
    logic [31:0] k;
    bit          known;
    verdict_t    verdict;
  } vector_t;

  logic clk;
  logic rst_n;
  llrk_in_if  in_bus();
  llrk_out_if out_bus();

  llr_primality_test_k2n_minus1_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  verdict_t    pending_verdicts[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned cycle_count;
  bit          stimulus_done;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Modular helpers at the 64-bit width of N.
  function automatic logic [63:0] fold_add(logic [63:0] a, logic [63:0] b, logic [63:0] n);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, n}) s = s - {1'b0, n};
    return s[63:0];
  endfunction

  function automatic logic [63:0] fold_sub(logic [63:0] a, logic [63:0] b, logic [63:0] n);
    return (a < b) ? (n - b + a) : (a - b);
  endfunction

  function automatic logic [63:0] fold_half(logic [63:0] v, logic [63:0] n);
    return v[0] ? ((v >> 1) + (n >> 1) + 64'd1) : (v >> 1);
  endfunction

  function automatic logic [63:0] fold_mul(logic [63:0] a, logic [63:0] b, logic [63:0] n);
    logic [63:0] r;
    r = '0;
    a = a % n;
    for (int i = 63; i >= 0; i--) begin
      r = fold_add(r, r, n);
      if (b[i]) r = fold_add(r, a, n);
    end
    return r;
  endfunction

  function automatic int jacobi_of(logic [63:0] a, logic [63:0] m);
    int          t;
    int unsigned z;
    logic [63:0] swap;
    t = 1;
    a = a % m;
    while (a != 0) begin
      z = 0;
      while (!a[0]) begin
        a = a >> 1;
        z++;
      end
      if ((z[0] & (m[1] ^ m[2])) ^ (a[1] & m[1])) t = -t;
      swap = a;
      a = m;
      m = swap;
      a = a % m;
    end
    return (m == 1) ? t : 0;
  endfunction

  function automatic logic [63:0] lucas_term(logic [63:0] p, logic [31:0] k, logic [63:0] n);
    logic [63:0] u, v, d, nu, nv;
    int          top;
    u = 64'd1;
    v = p;
    d = fold_sub(fold_mul(p, p, n), 64'd4, n);
    top = 31;
    while (top > 0 && !k[top]) top--;
    for (int i = top - 1; i >= 0; i--) begin
      nu = fold_mul(u, v, n);
      nv = fold_sub(fold_mul(v, v, n), 64'd2, n);
      u = nu;
      v = nv;
      if (k[i]) begin
        nu = fold_half(fold_add(fold_mul(u, p, n), v, n), n);
        nv = fold_half(fold_add(fold_mul(u, d, n), fold_mul(v, p, n), n), n);
        u = nu;
        v = nv;
      end
    end
    return v;
  endfunction

  function automatic verdict_t llr_verdict(logic [31:0] k);
    verdict_t    r;
    logic [63:0] n, v;
    int unsigned p;
    bit          found;
    r = '{prime: 1'b0, base: 16'd0, st: ST_KZERO};
    if (k == 0) return r;
    n = {k, 32'd0} - 64'd1;
    found = 1'b0;
    for (p = 3; p <= P_LIMIT; p++) begin
      if (jacobi_of(64'(p) - 64'd2, n) == 1 && jacobi_of(64'(p) + 64'd2, n) == -1) begin
        found = 1'b1;
        break;
      end
    end
    if (!found) begin
      r.st = ST_NOBASE;
      return r;
    end
    v = lucas_term(64'(p), k, n);
    for (int i = 0; i < SQUARINGS; i++) v = fold_sub(fold_mul(v, v, n), 64'd2, n);
    r.prime = (v == 0);
    r.base = p[15:0];
    r.st = ST_OK;
    return r;
  endfunction

  // Sender: directed vectors, then random multipliers, in bursts with gaps.
  initial begin
    vector_t     vectors[$];
    int unsigned burst_left;
    int unsigned gap;
    logic [31:0] k;
    int unsigned pick;
    vectors = '{
      '{32'd0,          1'b1, '{1'b0, 16'd0, ST_KZERO}},
      '{32'd1,          1'b0, '{1'b0, 16'd0, ST_OK}},
      '{32'd2,          1'b0, '{1'b0, 16'd0, ST_OK}},
      '{32'd3,          1'b0, '{1'b0, 16'd0, ST_OK}},
      '{32'd0,          1'b1, '{1'b0, 16'd0, ST_KZERO}},
      '{32'd5,          1'b0, '{1'b0, 16'd0, ST_OK}},
      '{32'd15,         1'b0, '{1'b0, 16'd0, ST_OK}},
      '{32'd255,        1'b0, '{1'b0, 16'd0, ST_OK}},
      '{32'hFFFF_FFFF,  1'b0, '{1'b0, 16'd0, ST_OK}},
      '{32'h8000_0000,  1'b0, '{1'b0, 16'd0, ST_OK}},
      '{32'h5555_5555,  1'b0, '{1'b0, 16'd0, ST_OK}},
      '{32'hAAAA_AAAA,  1'b0, '{1'b0, 16'd0, ST_OK}},
      '{32'h8000_0001,  1'b0, '{1'b0, 16'd0, ST_OK}},
      '{32'h0001_0000,  1'b0, '{1'b0, 16'd0, ST_OK}}
    };
    in_bus.valid <= 1'b0;
    in_bus.multiplier_k <= '0;
    stimulus_done = 1'b0;
    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    burst_left = 0;
    for (int idx = 0; idx < vectors.size() + RANDOM_ITEMS; idx++) begin
      if (idx < vectors.size()) begin
        k = vectors[idx].k;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 5) k = 32'd0;
        else if (pick < 25) k = $urandom;
        else k = $urandom_range(1, 4095);
      end
      if (burst_left == 0) begin
        gap = $urandom_range(1, 20);
        burst_left = $urandom_range(1, 6);
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left--;
      in_bus.valid <= 1'b1;
      in_bus.multiplier_k <= k;
      @(posedge clk);
      while (!in_bus.ready) @(posedge clk);
      if (idx < vectors.size() && vectors[idx].known)
        pending_verdicts.push_back(vectors[idx].verdict);
      else
        pending_verdicts.push_back(llr_verdict(k));
    end
    in_bus.valid <= 1'b0;
    stimulus_done = 1'b1;
  end

  // Receiver: short random stalls, one long hold-off after a few results.
  initial begin
    bit held;
    held = 1'b0;
    out_bus.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (!held && results_seen >= 8) begin
        held = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      out_bus.ready <= ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  end

  // Compare each result beat with the oldest pending verdict.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_seen <= results_seen + 1;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat at cycle %0d: prime %0b base %0d status %0d",
                   cycle_count, out_bus.is_probable_prime, out_bus.lucas_base,
                   out_bus.status);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_bus.is_probable_prime !== want.prime || out_bus.lucas_base !== want.base ||
            out_bus.status !== want.st) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: prime %0b/%0b base %0d/%0d status %0d/%0d (exp/act)",
                     want.prime, out_bus.is_probable_prime, want.base, out_bus.lucas_base,
                     want.st, out_bus.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    mismatches = 0;
    results_seen = 0;
    cycle_count = 0;
    wait (stimulus_done);
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
